[hw/rtl/ptts_pkg.sv]
// Package for the periodic task tick scheduler.
// Holds sizes, operation codes and the command word shared by the slot cells and the top level.
// No dependencies.
package ptts_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = 3;
    localparam int OP_W       = 3;
    localparam int DATA_W     = 16;
    localparam int MASK_W     = 8;

    typedef enum logic [OP_W-1:0] {
        OP_TICK    = 3'd0,
        OP_CREATE  = 3'd1,
        OP_DELETE  = 3'd2,
        OP_SUSPEND = 3'd3,
        OP_RESUME  = 3'd4
    } t_op;

    typedef struct packed {
        logic              valid;
        t_op               op;
        logic [DATA_W-1:0] period;
        logic [DATA_W-1:0] first_delay;
        logic              has_function;
    } t_cmd;

endpackage

[hw/rtl/ptts_slot.sv]
// One task slot: present and running flags, period and countdown.
// Applies the registered command word; depends on ptts_pkg.
module ptts_slot (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ptts_pkg::t_cmd i_cmd,
    input  logic          i_sel,
    output logic          o_fire,
    output logic          o_refused
);
    import ptts_pkg::*;

    logic              r_present;
    logic              r_running;
    logic [DATA_W-1:0] r_period;
    logic [DATA_W-1:0] r_countdown;

    logic w_tick;

    assign w_tick    = i_cmd.valid && (i_cmd.op == OP_TICK);
    assign o_fire    = w_tick && r_running && r_present && (r_countdown == '0);
    assign o_refused = i_cmd.valid && (i_cmd.op == OP_CREATE) && i_sel && r_present;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_present   <= 1'b0;
            r_running   <= 1'b0;
            r_period    <= '0;
            r_countdown <= '0;
        end else if (i_cmd.valid) begin
            unique case (i_cmd.op)
                OP_TICK: begin
                    if (r_running) begin
                        if (r_countdown != '0) begin
                            r_countdown <= r_countdown - DATA_W'(1);
                        end else if (r_present) begin
                            // reload; period 0 wraps to all ones
                            r_countdown <= r_period - DATA_W'(1);
                        end
                    end
                end
                OP_CREATE: begin
                    if (i_sel && !r_present) begin
                        r_period    <= i_cmd.period;
                        r_present   <= i_cmd.has_function;
                        r_running   <= 1'b1;
                        r_countdown <= i_cmd.first_delay;
                    end
                end
                OP_DELETE: begin
                    if (i_sel) begin
                        r_present <= 1'b0;
                    end
                end
                OP_SUSPEND: begin
                    if (i_sel) begin
                        r_running <= 1'b0;
                    end
                end
                OP_RESUME: begin
                    if (i_sel) begin
                        r_running <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    a_fire_reload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_fire |=> r_countdown == DATA_W'($past(r_period) - DATA_W'(1)))
        else $error("slot did not reload after firing");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.valid |=> $stable(r_countdown) && $stable(r_present) && $stable(r_running))
        else $error("slot state changed without a command");

    a_refused_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_refused |=> $stable(r_period) && $stable(r_countdown) && r_present)
        else $error("refused create altered the slot");

endmodule

[hw/rtl/periodic_task_tick_scheduler_unit.sv]
// Periodic task tick scheduler: input register, slot table, result register.
// start goes via the input and result registers to o_valid; one operation accepted every cycle.
// busy stays low: the strobed result cannot be held off and needs no stall.
// Rate is set by the parallel update of all slot cells in the single pass after the input register.
// Synchronous active-low reset empties and suspends every slot and clears the strobes.
module periodic_task_tick_scheduler_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [ptts_pkg::OP_W-1:0]    i_operation,
    input  logic [ptts_pkg::SLOT_W-1:0]  i_slot,
    input  logic [ptts_pkg::DATA_W-1:0]  i_period,
    input  logic [ptts_pkg::DATA_W-1:0]  i_first_delay,
    input  logic                         i_has_function,
    output logic                         o_valid,
    output logic [ptts_pkg::MASK_W-1:0]  o_fire_mask,
    output logic                         o_status
);
    import ptts_pkg::*;

    t_cmd              r_cmd;
    logic [SLOT_W-1:0] r_slot;
    logic              r_out_valid;
    logic [MASK_W-1:0] r_fire_mask;
    logic              r_status;

    logic [SLOT_COUNT-1:0] w_sel;
    logic [SLOT_COUNT-1:0] w_fire;
    logic [SLOT_COUNT-1:0] w_refused;
    logic [MASK_W-1:0]     n_fire_mask;

    assign busy = 1'b0;

    // input register: valid bit is control, the rest is payload
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd.valid <= 1'b0;
        end else begin
            r_cmd.valid <= start && !busy;
        end
        r_cmd.op           <= t_op'(i_operation);
        r_cmd.period       <= i_period;
        r_cmd.first_delay  <= i_first_delay;
        r_cmd.has_function <= i_has_function;
        r_slot             <= i_slot;
    end

    genvar gi;
    generate
        for (gi = 0; gi < SLOT_COUNT; gi++) begin : g_slot
            if (gi < (1 << SLOT_W)) begin : g_addr
                assign w_sel[gi] = (r_slot == SLOT_W'(gi));
            end else begin : g_noaddr
                assign w_sel[gi] = 1'b0;
            end

            ptts_slot u_slot (
                .i_clk     (i_clk),
                .i_rst_n   (i_rst_n),
                .i_cmd     (r_cmd),
                .i_sel     (w_sel[gi]),
                .o_fire    (w_fire[gi]),
                .o_refused (w_refused[gi])
            );
        end

        // slots past the mask width fire silently; mask bits past the slot count stay zero
        for (gi = 0; gi < MASK_W; gi++) begin : g_mask
            if (gi < SLOT_COUNT) begin : g_used
                assign n_fire_mask[gi] = w_fire[gi];
            end else begin : g_unused
                assign n_fire_mask[gi] = 1'b0;
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= r_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fire_mask <= n_fire_mask;
        r_status    <= |w_refused;
    end

    assign o_valid     = r_out_valid;
    assign o_fire_mask = r_fire_mask;
    assign o_status    = r_status;

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start |=> ##1 o_valid)
        else $error("word not delivered two cycles after start");

    a_status_no_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status |-> o_fire_mask == '0)
        else $error("refused create reported fired slots");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_cmd.valid))
        else $error("result strobe without an accepted word");

endmodule
